[src/todat_pkg.sv]
`timescale 1ns / 1ps
// shared types and constants for the time-of-day alarm table
// no dependencies; imported by time_of_day_alarm_table

package todat_pkg;

	// default table depth
	localparam int MAX_ENTRIES_DEF = 32;

	// largest legal clock time
	localparam logic [7:0] HOUR_MAX   = 8'd23;
	localparam logic [7:0] MINUTE_MAX = 8'd59;

	// request codes
	typedef enum logic [1:0] {
		OP_ADD    = 2'd0,
		OP_DELETE = 2'd1,
		OP_EDIT   = 2'd2,
		OP_CHECK  = 2'd3
	} op_t;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SHIFT
	} state_t;

	// one stored alarm
	typedef struct packed {
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic        enabled;
		logic [31:0] ident;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage

[src/todat_ram.sv]
`timescale 1ns / 1ps
// generic simple dual-port ram, one write and one registered read port
// no dependencies

module todat_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[src/time_of_day_alarm_table.sv]
`timescale 1ns / 1ps
// time-of-day alarm table: request sequencer around one entry ram
// depends on todat_pkg and todat_ram
//
// usage
//   a request (operation, entry_id, hour, minute, enable) is taken at a rising
//   edge with start high and busy low; busy stays low for an add or a
//   rejected edit, and goes high while the table is scanned
//   every result is shown for exactly one cycle with done high; last marks the
//   final result of a request; the receiver cannot hold results back
//   add: result in the cycle after the request; the next request may follow at once
//   delete / edit / check: the table is read one entry per cycle through the
//   ram's single registered read port; for delete, the entries behind the
//   removed one are read and written back one place lower
//   check emits one result per enabled matching alarm in table order; a match
//   is held until the next match or the scan end so that last can be set on
//   the final one, and with no match a single non-trigger result is sent
//   the ram is written at most once per cycle and never at an address that a
//   read still in flight needs, so no forwarding path is required
//   reset clears the entry count and sets the id counter to one; the ram
//   contents are not cleared, only entries below the count are ever read

module time_of_day_alarm_table
	import todat_pkg::*;
#(
	parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  operation,
	input  logic [31:0] entry_id,
	input  logic [7:0]  hour,
	input  logic [7:0]  minute,
	input  logic        enable,
	output logic        done,
	output logic        ok,
	output logic        trigger,
	output logic [31:0] result_id,
	output logic        last
);

	// index width and count width (count holds MAX_ENTRIES itself)
	localparam int IW = MAX_ENTRIES > 1 ? $clog2(MAX_ENTRIES) : 1;
	localparam int CW = $clog2(MAX_ENTRIES + 1);

	state_t state_q, state_d;

	// captured request
	op_t         op_q, op_d;
	logic [31:0] id_q, id_d;
	logic [7:0]  hour_q, hour_d;
	logic [7:0]  min_q, min_d;
	logic        en_q, en_d;

	// table bookkeeping
	logic [CW-1:0] count_q, count_d;
	logic [31:0]   next_id_q, next_id_d;

	// read pipeline
	logic [CW-1:0] rd_ptr_q, rd_ptr_d;
	logic          rd_vld_s1, rd_vld_d;
	logic [CW-1:0] rd_idx_s1;

	// held check match
	logic        pend_q, pend_d;
	logic [31:0] pend_id_q, pend_id_d;

	// result registers
	logic        done_q, done_d;
	logic        ok_q, ok_d;
	logic        trig_q, trig_d;
	logic [31:0] rid_q, rid_d;
	logic        last_q, last_d;

	// ram ports
	logic               ram_we, ram_re;
	logic [IW-1:0]      ram_waddr;
	entry_t             ram_wdata;
	logic [ENTRY_W-1:0] ram_rdata;
	entry_t             ent;

	logic accept, time_ok, full, hit_id, hit_chk, scan_end;

	assign accept   = start && !busy;
	assign time_ok  = (hour <= HOUR_MAX) && (minute <= MINUTE_MAX);
	assign full     = count_q >= CW'(MAX_ENTRIES);
	assign ent      = entry_t'(ram_rdata);
	assign hit_id   = rd_vld_s1 && (ent.ident == id_q);
	assign hit_chk  = rd_vld_s1 && ent.enabled && ({3'b000, ent.hour} == hour_q)
		&& ({2'b00, ent.minute} == min_q);
	assign scan_end = (rd_ptr_q == count_q) && !rd_vld_s1;
	// one read per cycle while busy and entries remain
	assign ram_re   = (state_q != ST_IDLE) && (rd_ptr_q < count_q);

	todat_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(MAX_ENTRIES)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(rd_ptr_q[IW-1:0]),
		.rdata(ram_rdata)
	);

	always_comb begin
		state_d   = state_q;
		op_d      = op_q;
		id_d      = id_q;
		hour_d    = hour_q;
		min_d     = min_q;
		en_d      = en_q;
		count_d   = count_q;
		next_id_d = next_id_q;
		rd_ptr_d  = rd_ptr_q + CW'(ram_re);
		rd_vld_d  = ram_re;
		pend_d    = pend_q;
		pend_id_d = pend_id_q;
		done_d    = 1'b0;
		ok_d      = 1'b0;
		trig_d    = 1'b0;
		rid_d     = '0;
		last_d    = 1'b1;
		ram_we    = 1'b0;
		ram_waddr = rd_idx_s1[IW-1:0];
		ram_wdata = ent;

		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					op_d   = op_t'(operation);
					id_d   = entry_id;
					hour_d = hour;
					min_d  = minute;
					en_d   = enable;
					if (op_t'(operation) == OP_ADD) begin
						done_d = 1'b1;
						if (!full && time_ok) begin
							// append at the end of the table
							ram_we    = 1'b1;
							ram_waddr = count_q[IW-1:0];
							ram_wdata = '{hour: hour[4:0], minute: minute[5:0],
								enabled: 1'b1, ident: next_id_q};
							ok_d      = 1'b1;
							rid_d     = next_id_q;
							count_d   = count_q + CW'(1);
							next_id_d = next_id_q + 32'd1;
						end
					end else if (op_t'(operation) == OP_EDIT && !time_ok) begin
						done_d = 1'b1;
					end else begin
						state_d  = ST_SCAN;
						rd_ptr_d = '0;
						pend_d   = 1'b0;
					end
				end
			end

			ST_SCAN: begin
				if (op_q == OP_CHECK) begin
					if (hit_chk) begin
						// release the previous match, hold this one
						if (pend_q) begin
							done_d = 1'b1;
							ok_d   = 1'b1;
							trig_d = 1'b1;
							rid_d  = pend_id_q;
							last_d = 1'b0;
						end
						pend_d    = 1'b1;
						pend_id_d = ent.ident;
					end else if (scan_end) begin
						done_d  = 1'b1;
						ok_d    = 1'b1;
						trig_d  = pend_q;
						rid_d   = pend_q ? pend_id_q : 32'd0;
						state_d = ST_IDLE;
					end
				end else begin
					if (hit_id) begin
						if (op_q == OP_EDIT) begin
							ram_we    = 1'b1;
							ram_wdata = '{hour: hour_q[4:0], minute: min_q[5:0],
								enabled: en_q, ident: ent.ident};
							done_d    = 1'b1;
							ok_d      = 1'b1;
							state_d   = ST_IDLE;
						end else begin
							// close the gap: restart reads just behind the hit
							state_d  = ST_SHIFT;
							rd_ptr_d = rd_idx_s1 + CW'(1);
							rd_vld_d = 1'b0;
						end
					end else if (scan_end) begin
						done_d  = 1'b1;
						state_d = ST_IDLE;
					end
				end
			end

			ST_SHIFT: begin
				if (rd_vld_s1) begin
					ram_we    = 1'b1;
					ram_waddr = rd_idx_s1[IW-1:0] - IW'(1);
				end
				if (scan_end) begin
					count_d = count_q - CW'(1);
					done_d  = 1'b1;
					ok_d    = 1'b1;
					state_d = ST_IDLE;
				end
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			next_id_q <= 32'd1;
			rd_vld_s1 <= 1'b0;
			pend_q    <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			state_q   <= state_d;
			count_q   <= count_d;
			next_id_q <= next_id_d;
			rd_vld_s1 <= rd_vld_d;
			pend_q    <= pend_d;
			done_q    <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		op_q      <= op_d;
		id_q      <= id_d;
		hour_q    <= hour_d;
		min_q     <= min_d;
		en_q      <= en_d;
		rd_ptr_q  <= rd_ptr_d;
		rd_idx_s1 <= rd_ptr_q;
		pend_id_q <= pend_id_d;
		ok_q      <= ok_d;
		trig_q    <= trig_d;
		rid_q     <= rid_d;
		last_q    <= last_d;
	end

	assign busy      = state_q != ST_IDLE;
	assign done      = done_q;
	assign ok        = ok_q;
	assign trigger   = trig_q;
	assign result_id = rid_q;
	assign last      = last_q;

`ifndef ASSERT_OFF
	// the table never holds more than its depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_ENTRIES))
		else $error("entry count above table depth");

	// data coming back from the ram always belongs to a live entry
	a_read_live: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> rd_idx_s1 < count_q)
		else $error("read returned beyond entry count");

	// a result that is not the final one is always a check trigger
	a_nonlast_trig: assert property (@(posedge clk) disable iff (!arst_n)
		done && !last |-> trigger && ok)
		else $error("non-final result that is not a trigger");

	// while idle only final results are pending on the output
	a_idle_last: assert property (@(posedge clk) disable iff (!arst_n)
		done && !busy |-> last)
		else $error("open result sequence while idle");

	// a check request always starts a scan
	a_check_scans: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && operation == OP_CHECK |=> busy)
		else $error("check request did not start a scan");
`endif

endmodule
